/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// Both macros sample on aclk and are disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GHT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ght_pkg.sv */
// ----------------------------------------------------------------------------
// ght_pkg
// Constants, codes and types shared by the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int LINK_W      = $clog2(TABLE_SLOTS + 1);
    localparam int VER_W       = 16;
    localparam int HVER_W      = 15;
    localparam int META_W      = VER_W + LINK_W;
    localparam int DATA_W      = 8 + 16;

    localparam logic [LINK_W-1:0] SLOT_END    = LINK_W'(TABLE_SLOTS);
    localparam logic [HVER_W-1:0] VERSION_MAX = HVER_W'(32767);

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_CLAIM  = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_NOT_FREE  = 3'd2;
    localparam logic [2:0] ST_STALE     = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX = 3'd4;

    typedef struct packed {
        logic [2:0]        status;
        logic [9:0]        out_handle_index;
        logic [HVER_W-1:0] out_handle_version;
        logic [7:0]        found_list_index;
        logic [15:0]       found_entity_index;
    } result_t;

    // A free slot holds a negative version; claiming it negates and adds one,
    // saturating at the largest handle version.
    function automatic logic [HVER_W-1:0] next_version(input logic [VER_W-1:0] v);
        logic signed [VER_W:0] n;
        n = (VER_W + 1)'(1) - $signed({v[VER_W-1], v});
        if (n > $signed({2'b00, VERSION_MAX})) begin
            return VERSION_MAX;
        end
        return n[HVER_W-1:0];
    endfunction

endpackage

/* rtl/ght_ram.sv */
// ----------------------------------------------------------------------------
// ght_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ght_out_stage.sv */
// ----------------------------------------------------------------------------
// ght_out_stage
// Output register of the result stream; holds one result until it is taken.
// ----------------------------------------------------------------------------
module ght_out_stage
    import ght_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  result_t     res,
    output logic        out_free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // out_handle_index, out_handle_version,
                                  // found_list_index, found_entity_index, zeros
    output logic [2:0]  m_tuser   // status
);

    logic    valid_reg;
    result_t data_reg;

    assign out_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = data_reg.status;
    assign m_tdata  = {7'b0, data_reg.found_entity_index, data_reg.found_list_index,
                       data_reg.out_handle_version, data_reg.out_handle_index};

endmodule

/* rtl/generational_handle_table.sv */
// ----------------------------------------------------------------------------
// generational_handle_table
// Slot map of versioned handles with a linked free list held in block RAM.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: s_tuser carries the command (allocate,
// allocate a named handle, look up a handle) and s_tdata the indexes and the
// handle. Each request yields exactly one result on the m_ stream: m_tuser
// carries the status, m_tdata the new handle or the stored indexes.
// Slot state lives in two RAMs with a registered read: a metadata RAM (version
// and free-list link) and a payload RAM (list and entity numbers).
// Allocate and lookup do one RAM read per request, then the check and
// write-back. Allocating a named slot that is not the free head walks
// the free list one link per cycle through the metadata read port.
// After reset the block sweeps the metadata RAM to build the free list,
// holding s_tready low. A stalled receiver is buffered by one output
// register; a further result waits inside and no new request is taken
// until it can be handed over.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module generational_handle_table
    import ght_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // list_index, entity_index, handle_index,
                                   // handle_version, zeros
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_handle_index, out_handle_version,
                                   // found_list_index, found_entity_index, zeros
    output logic [2:0]  m_tuser    // status
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_CLAIM = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [LINK_W-1:0] free_head_reg, free_head_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [7:0]        list_reg, list_next;
    logic [15:0]       ent_reg, ent_next;
    logic [9:0]        h_reg, h_next;
    logic [HVER_W-1:0] hver_reg, hver_next;
    logic [VER_W-1:0]  ver_h_reg, ver_h_next;
    logic [LINK_W-1:0] link_h_reg, link_h_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [LINK_W-1:0] steps_reg, steps_next;
    result_t           pend_reg, pend_next;

    logic              meta_we;
    logic [IDX_W-1:0]  meta_waddr, meta_raddr;
    logic [META_W-1:0] meta_wdata, meta_rdata;
    logic              data_we;
    logic [IDX_W-1:0]  data_waddr, data_raddr;
    logic [DATA_W-1:0] data_wdata, data_rdata;

    logic [VER_W-1:0]  rd_ver;
    logic [LINK_W-1:0] rd_link;
    logic [HVER_W-1:0] nv_rd, nv_h;
    logic              h_bad;
    logic              fin;
    result_t           fin_res;
    logic              out_load, out_free;
    result_t           out_res;

    logic [1:0]        s_cmd;
    logic [7:0]        s_list;
    logic [15:0]       s_ent;
    logic [9:0]        s_h;
    logic [HVER_W-1:0] s_hver;

    assign s_cmd  = s_tuser;
    assign s_list = s_tdata[7:0];
    assign s_ent  = s_tdata[23:8];
    assign s_h    = s_tdata[33:24];
    assign s_hver = s_tdata[48:34];

    assign s_tready = (state_reg == S_IDLE);

    assign rd_ver  = meta_rdata[META_W-1:LINK_W];
    assign rd_link = meta_rdata[LINK_W-1:0];
    assign nv_rd   = next_version(rd_ver);
    assign nv_h    = next_version(ver_h_reg);
    assign h_bad   = (32'(h_reg) >= 32'(TABLE_SLOTS));

    ght_ram #(.WIDTH(META_W), .DEPTH(TABLE_SLOTS)) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    ght_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_SLOTS)) u_data_ram (
        .aclk  (aclk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    ght_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .res      (out_res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // The payload read is only consumed by a lookup, in the cycle after accept.
    assign data_raddr = IDX_W'(s_h);

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        free_head_next = free_head_reg;
        cmd_next       = cmd_reg;
        list_next      = list_reg;
        ent_next       = ent_reg;
        h_next         = h_reg;
        hver_next      = hver_reg;
        ver_h_next     = ver_h_reg;
        link_h_next    = link_h_reg;
        idx_next       = idx_reg;
        steps_next     = steps_reg;
        pend_next      = pend_reg;
        meta_we        = 1'b0;
        meta_waddr     = '0;
        meta_wdata     = '0;
        meta_raddr     = IDX_W'(h_reg);
        data_we        = 1'b0;
        data_waddr     = IDX_W'(h_reg);
        data_wdata     = {ent_reg, list_reg};
        fin            = 1'b0;
        fin_res        = '0;
        out_load       = 1'b0;
        out_res        = pend_reg;

        unique case (state_reg)
            S_CLEAR: begin
                meta_we    = 1'b1;
                meta_waddr = clr_reg;
                meta_wdata = {{VER_W{1'b1}}, LINK_W'(clr_reg) + LINK_W'(1)};
                clr_next   = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(TABLE_SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                meta_raddr = (s_cmd == CMD_ALLOC) ? free_head_reg[IDX_W-1:0]
                                                  : IDX_W'(s_h);
                if (s_tvalid) begin
                    cmd_next   = s_cmd;
                    list_next  = s_list;
                    ent_next   = s_ent;
                    h_next     = s_h;
                    hver_next  = s_hver;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                case (cmd_reg)
                    CMD_ALLOC: begin
                        if (free_head_reg >= SLOT_END) begin
                            fin            = 1'b1;
                            fin_res.status = ST_FULL;
                        end else if (!rd_ver[VER_W-1]) begin
                            fin            = 1'b1;
                            fin_res.status = ST_NOT_FREE;
                        end else begin
                            free_head_next             = rd_link;
                            meta_we                    = 1'b1;
                            meta_waddr                 = free_head_reg[IDX_W-1:0];
                            meta_wdata                 = {1'b0, nv_rd, rd_link};
                            data_we                    = 1'b1;
                            data_waddr                 = free_head_reg[IDX_W-1:0];
                            fin                        = 1'b1;
                            fin_res.status             = ST_OK;
                            fin_res.out_handle_index   = 10'(free_head_reg);
                            fin_res.out_handle_version = nv_rd;
                        end
                    end
                    CMD_CLAIM: begin
                        if (h_bad) begin
                            fin            = 1'b1;
                            fin_res.status = ST_BAD_INDEX;
                        end else if (!rd_ver[VER_W-1]) begin
                            fin            = 1'b1;
                            fin_res.status = ST_NOT_FREE;
                        end else if (free_head_reg == LINK_W'(h_reg)) begin
                            free_head_next             = rd_link;
                            meta_we                    = 1'b1;
                            meta_waddr                 = IDX_W'(h_reg);
                            meta_wdata                 = {1'b0, nv_rd, rd_link};
                            data_we                    = 1'b1;
                            fin                        = 1'b1;
                            fin_res.status             = ST_OK;
                            fin_res.out_handle_index   = h_reg;
                            fin_res.out_handle_version = nv_rd;
                        end else begin
                            // Remember the named slot, then walk from the head
                            // looking for its predecessor.
                            link_h_next = rd_link;
                            ver_h_next  = rd_ver;
                            if (free_head_reg >= SLOT_END) begin
                                fin            = 1'b1;
                                fin_res.status = ST_NOT_FREE;
                            end else begin
                                meta_raddr = free_head_reg[IDX_W-1:0];
                                idx_next   = free_head_reg[IDX_W-1:0];
                                steps_next = '0;
                                state_next = S_WALK;
                            end
                        end
                    end
                    CMD_LOOKUP: begin
                        fin = 1'b1;
                        if (h_bad) begin
                            fin_res.status = ST_BAD_INDEX;
                        end else if (rd_ver[VER_W-1] || rd_ver[HVER_W-1:0] != hver_reg) begin
                            fin_res.status = ST_STALE;
                        end else begin
                            fin_res.status             = ST_OK;
                            fin_res.found_list_index   = data_rdata[7:0];
                            fin_res.found_entity_index = data_rdata[23:8];
                        end
                    end
                    default: begin
                        fin            = 1'b1;
                        fin_res.status = ST_BAD_INDEX;
                    end
                endcase
            end
            S_WALK: begin
                if (rd_link == LINK_W'(h_reg)) begin
                    // Predecessor found: splice the named slot out of the list.
                    meta_we    = 1'b1;
                    meta_waddr = idx_reg;
                    meta_wdata = {rd_ver, link_h_reg};
                    state_next = S_CLAIM;
                end else if (rd_link >= SLOT_END || steps_reg + LINK_W'(1) >= SLOT_END) begin
                    fin            = 1'b1;
                    fin_res.status = ST_NOT_FREE;
                end else begin
                    meta_raddr = rd_link[IDX_W-1:0];
                    idx_next   = rd_link[IDX_W-1:0];
                    steps_next = steps_reg + LINK_W'(1);
                end
            end
            S_CLAIM: begin
                meta_we                    = 1'b1;
                meta_waddr                 = IDX_W'(h_reg);
                meta_wdata                 = {1'b0, nv_h, link_h_reg};
                data_we                    = 1'b1;
                fin                        = 1'b1;
                fin_res.status             = ST_OK;
                fin_res.out_handle_index   = h_reg;
                fin_res.out_handle_version = nv_h;
            end
            S_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_res    = pend_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (fin) begin
            if (out_free) begin
                out_load   = 1'b1;
                out_res    = fin_res;
                state_next = S_IDLE;
            end else begin
                pend_next  = fin_res;
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            free_head_reg <= '0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_head_reg <= free_head_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        list_reg   <= list_next;
        ent_reg    <= ent_next;
        h_reg      <= h_next;
        hver_reg   <= hver_next;
        ver_h_reg  <= ver_h_next;
        link_h_reg <= link_h_next;
        idx_reg    <= idx_next;
        steps_reg  <= steps_next;
        pend_reg   <= pend_next;
    end

    `GHT_ASSERT_SAME(a_head_range, 1'b1, free_head_reg <= SLOT_END,
        "free list head beyond the end marker")
    `GHT_ASSERT_SAME(a_no_write_idle, state_reg == S_IDLE, !meta_we && !data_we,
        "table written while waiting for a request")
    `GHT_ASSERT_SAME(a_load_free, out_load, out_free,
        "result loaded over an unconsumed result")
    `GHT_ASSERT_SAME(a_walk_bound, state_reg == S_WALK, steps_reg < SLOT_END,
        "free list walk ran past its bound")
    `GHT_ASSERT_NEXT(a_claim_after_splice, state_reg == S_WALK && state_next == S_CLAIM,
        meta_we && meta_waddr == IDX_W'(h_reg),
        "named slot not written after splicing it out")

endmodule
